[rtl/scit_pkg.sv]
// ----------------------------------------------------------------------------
// scit_pkg
// Shared types and constants of the sorted chunk index table.
// ----------------------------------------------------------------------------
package scit_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = $clog2(TableDepth + 1);

  localparam logic ReqInsert = 1'b0;
  localparam logic ReqRemove = 1'b1;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] chunk_offset;
    logic [15:0] point_count;
    logic [31:0] shard_id;
  } entry_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] chunk_offset;
    logic [15:0] point_count;
    logic [31:0] shard_id;
    logic        shard_has_new;
    logic        shard_loading;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        mark_new_values;
    logic        mark_overlap;
    logic        any_overlap;
    logic [8:0]  removed_entries;
    logic [23:0] removed_points;
    logic [8:0]  entry_total;
  } rsp_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_req;     // capture request, reset scan state for reads from count-1 / index 0
    logic rd_en;        // issue memory read at rd_addr
    logic [AddrW-1:0] rd_addr;
    logic ins_step;     // evaluate read data during insert scan
    logic rem_step;     // evaluate read data during remove scan
    logic ins_place;    // write new entry at ins index
    logic finish;       // compose response
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic              shift;   // insert scan: entry moves up
    logic              full;
  } sts_t;

endpackage

[rtl/scit_if.sv]
// ----------------------------------------------------------------------------
// scit_req_if / scit_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface scit_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] start_time;
  logic [31:0] end_time;
  logic [31:0] chunk_offset;
  logic [15:0] point_count;
  logic [31:0] shard_id;
  logic        shard_has_new;
  logic        shard_loading;
  modport source (output valid, req_type, start_time, end_time, chunk_offset, point_count,
                  shard_id, shard_has_new, shard_loading, input ready);
  modport sink (input valid, req_type, start_time, end_time, chunk_offset, point_count,
                shard_id, shard_has_new, shard_loading, output ready);
endinterface

interface scit_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        mark_new_values;
  logic        mark_overlap;
  logic        any_overlap;
  logic [8:0]  removed_entries;
  logic [23:0] removed_points;
  logic [8:0]  entry_total;
  modport source (output valid, status, mark_new_values, mark_overlap, any_overlap,
                  removed_entries, removed_points, entry_total, input ready);
  modport sink (input valid, status, mark_new_values, mark_overlap, any_overlap,
                removed_entries, removed_points, entry_total, output ready);
endinterface

[rtl/scit_datapath.sv]
// ----------------------------------------------------------------------------
// scit_datapath
// Entry memory, request register, scan pointers and result composition.
// ----------------------------------------------------------------------------
module scit_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scit_pkg::req_t  req_i,
  input  scit_pkg::cmd_t  cmd_i,
  output scit_pkg::sts_t  sts_o,
  output scit_pkg::rsp_t  rsp_o
);
  import scit_pkg::*;

  entry_t mem_q [TableDepth];
  entry_t rd_q;

  req_t              req_q;
  logic [CountW-1:0] count_q, count_d;
  logic              ovl_q, ovl_d;
  logic [CountW-1:0] ins_q, ins_d;
  logic [CountW-1:0] wr_q, wr_d;
  logic [CountW-1:0] gap_q, gap_d;
  logic [23:0]       pts_q, pts_d;
  logic              has_prev_q, has_prev_d;
  entry_t            prev_q, prev_d;
  entry_t            next_q, next_d;
  logic              has_next_q, has_next_d;
  rsp_t              rsp_q, rsp_d;

  logic              we;
  logic [AddrW-1:0]  waddr;
  entry_t            wdata;
  logic              shift;
  logic              match;
  logic              mnew, movl;
  entry_t            new_e;

  assign new_e = '{req_q.start_time, req_q.end_time, req_q.chunk_offset,
                   req_q.point_count, req_q.shard_id};
  assign shift = req_q.start_time < rd_q.start_time;
  assign match = rd_q.shard_id == req_q.shard_id;

  always_comb begin
    we = 1'b0;
    waddr = ins_q[AddrW-1:0];
    wdata = new_e;
    count_d = count_q;
    ovl_d = ovl_q;
    ins_d = ins_q;
    wr_d = wr_q;
    gap_d = gap_q;
    pts_d = pts_q;
    has_prev_d = has_prev_q;
    prev_d = prev_q;
    next_d = next_q;
    has_next_d = has_next_q;
    rsp_d = rsp_q;
    mnew = 1'b0;
    movl = 1'b0;
    if (cmd_i.load_req) begin
      ins_d = count_q;
      wr_d = '0;
      gap_d = '0;
      pts_d = '0;
      has_prev_d = 1'b0;
      has_next_d = 1'b0;
    end
    if (cmd_i.ins_step) begin
      if (shift) begin
        we = 1'b1;
        waddr = ins_q[AddrW-1:0];
        wdata = rd_q;
        ins_d = ins_q - 1'b1;
        next_d = rd_q;
        has_next_d = 1'b1;
      end else begin
        prev_d = rd_q;
        has_prev_d = 1'b1;
      end
    end
    if (cmd_i.rem_step) begin
      if (match) begin
        gap_d = gap_q + 1'b1;
        pts_d = pts_q + 24'(rd_q.point_count);
      end else begin
        we = 1'b1;
        waddr = wr_q[AddrW-1:0];
        wdata = rd_q;
        wr_d = wr_q + 1'b1;
      end
    end
    if (cmd_i.ins_place) begin
      we = 1'b1;
      waddr = ins_q[AddrW-1:0];
      wdata = new_e;
    end
    if (cmd_i.finish) begin
      rsp_d = '0;
      if (req_q.req_type == ReqInsert) begin
        if (count_q == CountW'(TableDepth)) begin
          rsp_d.status = 1'b1;
        end else begin
          mnew = !req_q.shard_has_new && !req_q.shard_loading &&
                 ((has_prev_q && prev_q.shard_id == req_q.shard_id) ||
                  (has_next_q && next_q.shard_id == req_q.shard_id));
          movl = (has_prev_q && prev_q.end_time > req_q.start_time) ||
                 (has_next_q && req_q.end_time > next_q.start_time);
          rsp_d.mark_new_values = mnew;
          rsp_d.mark_overlap = movl;
          count_d = count_q + 1'b1;
          ovl_d = ovl_q | movl;
        end
      end else begin
        count_d = count_q - gap_q;
        rsp_d.removed_entries = 9'(gap_q);
        rsp_d.removed_points = pts_q;
      end
      rsp_d.any_overlap = ovl_d;
      rsp_d.entry_total = 9'(count_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (cmd_i.rd_en) rd_q <= mem_q[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    wr_q <= wr_d;
    ins_q <= ins_d;
    gap_q <= gap_d;
    pts_q <= pts_d;
    has_prev_q <= has_prev_d;
    prev_q <= prev_d;
    next_q <= next_d;
    has_next_q <= has_next_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovl_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ovl_q <= ovl_d;
    end
  end

  assign sts_o.count = count_q;
  assign sts_o.shift = shift;
  assign sts_o.full = count_q == CountW'(TableDepth);
  assign rsp_o = rsp_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(TableDepth)) else $error("count over depth");
  a_ovl_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(ovl_q) |-> ovl_q) else $error("overlap flag cleared");
  a_no_dual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.ins_step && cmd_i.rem_step)) else $error("insert and remove steps together");
`endif
endmodule

[rtl/scit_ctrl.sv]
// ----------------------------------------------------------------------------
// scit_ctrl
// Sequencer for insert scans and for remove compaction at one entry per cycle.
// ----------------------------------------------------------------------------
module scit_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_type_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  input  scit_pkg::sts_t sts_i,
  output scit_pkg::cmd_t cmd_o
);
  import scit_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StIns   = 6'b000010,
    StPlace = 6'b000100,
    StRem   = 6'b001000,
    StFin   = 6'b010000,
    StRsp   = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] left_q, left_d;   // entries still to read
  logic [CountW-1:0] ptr_q, ptr_d;     // next read index
  logic              busy_q, busy_d;   // a read is outstanding
  logic              rsp_valid_q, rsp_valid_d;
  logic              accept;

  assign req_ready_o = (state_q == StIdle) && !rsp_valid_q;
  assign accept = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d = state_q;
    left_d = left_q;
    ptr_d = ptr_q;
    busy_d = busy_q;
    rsp_valid_d = rsp_valid_q;
    cmd_o = '0;
    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load_req = 1'b1;
          busy_d = 1'b0;
          if (req_type_i == ReqRemove) begin
            ptr_d = '0;
            left_d = sts_i.count;
            state_d = StRem;
          end else if (sts_i.full) begin
            state_d = StFin;
          end else begin
            ptr_d = sts_i.count;
            left_d = sts_i.count;
            state_d = StIns;
          end
        end
      end
      StIns: begin
        if (busy_q) begin
          cmd_o.ins_step = 1'b1;
          busy_d = 1'b0;
          if (!sts_i.shift) state_d = StPlace;
        end else if (left_q == '0) begin
          state_d = StPlace;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_addr = AddrW'(ptr_q - 1'b1);
          ptr_d = ptr_q - 1'b1;
          left_d = left_q - 1'b1;
          busy_d = 1'b1;
        end
      end
      StPlace: begin
        cmd_o.ins_place = 1'b1;
        state_d = StFin;
      end
      StRem: begin
        if (busy_q) begin
          cmd_o.rem_step = 1'b1;
          busy_d = 1'b0;
        end
        if (left_q != '0) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_addr = ptr_q[AddrW-1:0];
          ptr_d = ptr_q + 1'b1;
          left_d = left_q - 1'b1;
          busy_d = 1'b1;
        end else if (!busy_q) begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        state_d = StRsp;
      end
      StRsp: begin
        rsp_valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      left_q <= '0;
      ptr_q <= '0;
      busy_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      left_q <= left_d;
      ptr_q <= ptr_d;
      busy_q <= busy_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_rsp_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFin |=> state_q == StRsp) else $error("finish not followed by result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_ready_i |=> rsp_valid_q) else $error("result dropped");
`endif
endmodule

[rtl/sorted_chunk_index_table.sv]
// ----------------------------------------------------------------------------
// sorted_chunk_index_table
// Start-sorted table of chunk descriptors with insert and shard removal.
// ----------------------------------------------------------------------------
// One request at a time. An insert reads the table from the top down, one entry
// at a time (a read, then a compare and move), moving each larger-start entry
// up until it reads an entry that does not move. A full-table insert skips the
// scan. A remove reads every stored entry once and writes the survivors down in
// the same pass, one entry per cycle. The next request is taken once the result
// has been taken.
module sorted_chunk_index_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  scit_req_if.sink   req_i,
  scit_rsp_if.source rsp_o
);
  import scit_pkg::*;

  req_t req;
  rsp_t rsp;
  cmd_t cmd;
  sts_t sts;

  assign req = '{req_i.req_type, req_i.start_time, req_i.end_time, req_i.chunk_offset,
                 req_i.point_count, req_i.shard_id, req_i.shard_has_new,
                 req_i.shard_loading};

  scit_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(req_i.valid), .req_type_i(req_i.req_type), .req_ready_o(req_i.ready),
    .rsp_valid_o(rsp_o.valid), .rsp_ready_i(rsp_o.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  scit_datapath u_dp (
    .clk_i, .rst_ni, .req_i(req), .cmd_i(cmd), .sts_o(sts), .rsp_o(rsp)
  );

  assign rsp_o.status = rsp.status;
  assign rsp_o.mark_new_values = rsp.mark_new_values;
  assign rsp_o.mark_overlap = rsp.mark_overlap;
  assign rsp_o.any_overlap = rsp.any_overlap;
  assign rsp_o.removed_entries = rsp.removed_entries;
  assign rsp_o.removed_points = rsp.removed_points;
  assign rsp_o.entry_total = rsp.entry_total;
endmodule

[tb/scit_tb_if.sv]
// ----------------------------------------------------------------------------
// scit testbench channels
// The block's request and result channels come from rtl/scit_if.sv; this file
// holds the testbench's own types for a predicted result.
// ----------------------------------------------------------------------------
package scit_tb_pkg;
  import scit_pkg::*;

  typedef struct {
    logic        status;
    logic        mark_new_values;
    logic        mark_overlap;
    logic        any_overlap;
    logic [8:0]  removed_entries;
    logic [23:0] removed_points;
    logic [8:0]  entry_total;
  } table_result_t;
endpackage

[tb/scit_checker.sv]
// ----------------------------------------------------------------------------
// scit_checker
// Watches the request and result channels, keeps its own sorted copy of the
// chunk table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module scit_checker
  import scit_pkg::*;
  import scit_tb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  scit_req_if        req_i,
  scit_rsp_if        rsp_i,
  output int         errors_o,
  output int         pending_o,
  output int         inserts_o,
  output int         removes_o,
  output int         overlaps_o,
  output int         fulls_o
);
  timeunit 1ns;
  timeprecision 1ps;

  entry_t        chunks[$];
  logic          sticky_overlap;
  table_result_t awaited_results[$];

  assign pending_o = awaited_results.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  function automatic table_result_t apply_request(input req_t r);
    table_result_t res;
    entry_t        e;
    int            pos;
    int            n;
    entry_t        kept[$];
    res = '{default: '0};
    if (r.req_type == ReqInsert) begin
      inserts_o++;
      if (chunks.size() >= TableDepth) begin
        res.status = 1'b1;
        fulls_o++;
      end else begin
        pos = chunks.size();
        while (pos > 0 && r.start_time < chunks[pos-1].start_time) pos--;
        e = '{r.start_time, r.end_time, r.chunk_offset, r.point_count, r.shard_id};
        chunks.insert(pos, e);
        n = chunks.size();
        if (!r.shard_has_new && !r.shard_loading &&
            ((pos > 0 && chunks[pos-1].shard_id == r.shard_id) ||
             (pos + 1 < n && chunks[pos+1].shard_id == r.shard_id)))
          res.mark_new_values = 1'b1;
        if ((pos > 0 && chunks[pos-1].end_time > r.start_time) ||
            (pos + 1 < n && r.end_time > chunks[pos+1].start_time)) begin
          res.mark_overlap = 1'b1;
          sticky_overlap = 1'b1;
          overlaps_o++;
        end
      end
    end else begin
      removes_o++;
      foreach (chunks[k]) begin
        if (chunks[k].shard_id == r.shard_id) begin
          res.removed_entries++;
          res.removed_points += chunks[k].point_count;
        end else begin
          kept.push_back(chunks[k]);
        end
      end
      chunks = kept;
    end
    res.any_overlap = sticky_overlap;
    res.entry_total = 9'(chunks.size());
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    if (!rst_ni) begin
      chunks.delete();
      awaited_results.delete();
      sticky_overlap <= 1'b0;
      errors_o <= 0;
      inserts_o <= 0;
      removes_o <= 0;
      overlaps_o <= 0;
      fulls_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_results.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          errors_o++;
        end else begin
          want = awaited_results.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch("status", rsp_i.status, want.status);
          if (rsp_i.mark_new_values !== want.mark_new_values)
            report_mismatch("mark_new_values", rsp_i.mark_new_values, want.mark_new_values);
          if (rsp_i.mark_overlap !== want.mark_overlap)
            report_mismatch("mark_overlap", rsp_i.mark_overlap, want.mark_overlap);
          if (rsp_i.any_overlap !== want.any_overlap)
            report_mismatch("any_overlap", rsp_i.any_overlap, want.any_overlap);
          if (rsp_i.removed_entries !== want.removed_entries)
            report_mismatch("removed_entries", rsp_i.removed_entries, want.removed_entries);
          if (rsp_i.removed_points !== want.removed_points)
            report_mismatch("removed_points", rsp_i.removed_points, want.removed_points);
          if (rsp_i.entry_total !== want.entry_total)
            report_mismatch("entry_total", rsp_i.entry_total, want.entry_total);
        end
      end
      if (req_i.valid && req_i.ready)
        awaited_results.push_back(apply_request('{req_i.req_type, req_i.start_time,
          req_i.end_time, req_i.chunk_offset, req_i.point_count, req_i.shard_id,
          req_i.shard_has_new, req_i.shard_loading}));
    end
  end
endmodule

[tb/sorted_chunk_index_table_tb.sv]
// ----------------------------------------------------------------------------
// sorted_chunk_index_table_tb
// Drives directed and random inserts and shard removals with random gaps and
// result stalls; the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module sorted_chunk_index_table_tb;
  import scit_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  logic clk_i;
  logic rst_ni;
  int   errors, pending, inserts, removes, overlaps, fulls;
  int   idle_cycles;

  scit_req_if req_if ();
  scit_rsp_if rsp_if ();

  sorted_chunk_index_table dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  scit_checker checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .errors_o  (errors),
    .pending_o (pending),
    .inserts_o (inserts),
    .removes_o (removes),
    .overlaps_o(overlaps),
    .fulls_o   (fulls)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int gap;
    rsp_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 9) < 3) gap = 0;
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic send_request(input logic kind, input logic [31:0] st, input logic [31:0] en,
                              input logic [31:0] off, input logic [15:0] pts,
                              input logic [31:0] shard, input logic flagged,
                              input logic loading);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 9) < 3) gap = 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.req_type      <= kind;
    req_if.start_time    <= st;
    req_if.end_time      <= en;
    req_if.chunk_offset  <= off;
    req_if.point_count   <= pts;
    req_if.shard_id      <= shard;
    req_if.shard_has_new <= flagged;
    req_if.shard_loading <= loading;
    req_if.valid         <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_chunk(input logic [31:0] st, input logic [31:0] en,
                            input logic [31:0] shard);
    send_request(ReqInsert, st, en, $urandom, 16'($urandom), shard,
                 1'($urandom), 1'($urandom));
  endtask

  task automatic drop_shard(input logic [31:0] shard);
    send_request(ReqRemove, $urandom, $urandom, $urandom, 16'($urandom), shard,
                 1'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [31:0] st, len, shard;
    int          sent;
    int          mode;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = ReqInsert;
    req_if.start_time = '0;
    req_if.end_time = '0;
    req_if.chunk_offset = '0;
    req_if.point_count = '0;
    req_if.shard_id = '0;
    req_if.shard_has_new = 1'b0;
    req_if.shard_loading = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    drop_shard(32'd5);
    send_request(ReqInsert, 32'd100, 32'd200, 32'd0, 16'hFFFF, 32'd1, 1'b0, 1'b0);
    send_request(ReqInsert, 32'd100, 32'd150, 32'hFFFF_FFFF, 16'd0, 32'd1, 1'b0, 1'b0);
    send_request(ReqInsert, 32'd0, 32'd50, 32'd7, 16'd1, 32'd1, 1'b1, 1'b0);
    send_request(ReqInsert, 32'd300, 32'd400, 32'd7, 16'd2, 32'd1, 1'b0, 1'b1);
    send_request(ReqInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 16'd3, 32'hFFFF_FFFF,
                 1'b0, 1'b0);
    send_request(ReqInsert, 32'd250, 32'd260, 32'd1, 16'd4, 32'h0, 1'b0, 1'b0);
    send_request(ReqInsert, 32'd40, 32'd45, 32'd1, 16'd5, 32'd2, 1'b0, 1'b0);
    drop_shard(32'd1);
    drop_shard(32'hFFFF_FFFF);
    drop_shard(32'd77);
    wait_drained();

    // fill to the top, hit the full table four times, then remove shards 9 to 12 and 0
    for (int k = 0; k < TableDepth; k++)
      send_request(ReqInsert, 32'($urandom_range(0, 3000)), $urandom, $urandom, 16'hFFFF,
                   (k % 3 == 0) ? 32'd9 : 32'($urandom_range(10, 12)), 1'($urandom),
                   1'($urandom));
    send_chunk(32'd5, 32'd6, 32'd9);
    send_chunk(32'd5, 32'd6, 32'd13);
    drop_shard(32'd9);
    drop_shard(32'd10);
    drop_shard(32'd11);
    drop_shard(32'd12);
    drop_shard(32'd0);

    sent = 0;
    while (sent < 1500) begin
      mode = $urandom_range(0, 9);
      if (sent == 700) wait_drained();
      if (mode < 6) begin
        st = $urandom_range(0, 5000);
        len = $urandom_range(0, 60);
        shard = $urandom_range(0, 7);
        send_chunk(st, st + len, shard);
      end else if (mode < 8) begin
        send_chunk($urandom, $urandom, $urandom_range(0, 7));
      end else begin
        drop_shard((mode == 9) ? $urandom : 32'($urandom_range(0, 7)));
      end
      sent++;
    end
    wait_drained();
    repeat (600) @(negedge clk_i);

    $display("covered %0d inserts (%0d refused as full, %0d overlapping) and %0d removals",
             inserts, fulls, overlaps, removes);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
